### rtl/sliding_window_median_macros.svh
// Assertion macros used by the port-level checker of the sliding window median block.
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define SWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sliding_window_median: check failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define SWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sliding_window_median: check failed");

`endif

### rtl/swm_pkg.sv
// Types and constants shared by the sliding window median modules.
package swm_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned CFG_W    = 5;
    localparam int unsigned AGE_W    = 5;
    localparam int unsigned RES_W    = 33;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [CFG_W-1:0]           size_t;
    typedef logic [AGE_W-1:0]           age_t;
    typedef logic signed [RES_W-1:0]    result_t;

    // One slot of the sorted window: its value and how many samples ago it arrived.
    typedef struct packed {
        sample_t value;
        age_t    age;
    } entry_t;

    // Controls broadcast from the top level to every cell.
    typedef struct packed {
        logic    enable;
        sample_t sample;
        size_t   limit;
        age_t    oldest;
        logic    full;
        size_t   lo_idx;
        size_t   hi_idx;
    } cell_ctl_t;

endpackage

### rtl/swm_cell.sv
// One compare-and-shift cell of the sorted window chain.
module swm_cell
    import swm_pkg::*;
#(
    parameter int unsigned INDEX = 0
)
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  entry_t    left_shift,
    input  logic      left_gt,
    input  logic      del_in,
    input  entry_t    right_entry,
    output entry_t    entry,
    output entry_t    shift_entry,
    output logic      gt_out,
    output logic      del_out,
    output sample_t   lo_tap,
    output sample_t   hi_tap
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   beyond;
    logic   is_lo;
    logic   is_hi;
    logic   past_del;

    // Cells whose position cannot be named by a window size sit beyond every limit.
    if (INDEX < (1 << CFG_W)) begin : g_near
        assign beyond = (CFG_W'(INDEX) >= ctl.limit);
        assign is_lo  = (CFG_W'(INDEX) == ctl.lo_idx);
        assign is_hi  = (CFG_W'(INDEX) == ctl.hi_idx);
    end else begin : g_far
        assign beyond = 1'b1;
        assign is_lo  = 1'b0;
        assign is_hi  = 1'b0;
    end

    // The departing sample is at or left of this cell, so the list closes up from the right.
    assign past_del    = del_in || (ctl.full && (entry_reg.age == ctl.oldest));
    assign del_out     = past_del;
    assign shift_entry = past_del ? right_entry : entry_reg;
    assign gt_out      = beyond || (shift_entry.value > ctl.sample);

    always_comb
    begin
        if (left_gt) begin
            entry_next.value = left_shift.value;
            entry_next.age   = left_shift.age + AGE_W'(1);
        end else if (gt_out) begin
            entry_next.value = ctl.sample;
            entry_next.age   = '0;
        end else begin
            entry_next.value = shift_entry.value;
            entry_next.age   = shift_entry.age + AGE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.enable) begin
            entry_reg <= entry_next;
        end
    end

    assign entry  = entry_reg;
    assign lo_tap = is_lo ? entry_reg.value : '0;
    assign hi_tap = is_hi ? entry_reg.value : '0;

endmodule

### rtl/sliding_window_median.sv
// Top level of the sliding window median filter: control, cell chain and output register.
//
// Usage: samples arrive on the input channel (in_valid/in_ready, fields sample and
// restart) and medians leave on the output channel (out_valid/out_ready, field
// median_times_two, the sum of the two middle window elements). One beat in gives
// at most one beat out: nothing until the window holds window_size samples since the
// last restart, then one result per sample. A beat with restart set empties the
// window before its sample is taken. window_size is written through cfg_we while the
// block is idle; values of zero count as one and values above WINDOW_MAX saturate,
// and any write empties the window.
// A sample taken by the cell chain sets fire_reg, and its result is loaded into the output
// register when the output stage moves. Throughput: one sample per cycle while the output
// is not stalled, set by the cell chain, which removes the oldest sample and inserts the new
// one in a single compare-and-shift step. When the receiver stalls, the result holds in the
// output register, and the chain still takes samples until it holds the next result; after
// that in_ready stays low until the output is taken. Reset empties the window, sets the
// window size to one and drops any pending result; no clearing pass is needed.
module sliding_window_median
    import swm_pkg::*;
#(
    parameter int unsigned WINDOW_MAX = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  size_t          window_size,
    input  logic           in_valid,
    output logic           in_ready,
    input  sample_t        sample,
    input  logic           restart,
    output logic           out_valid,
    input  logic           out_ready,
    output result_t        median_times_two
);

    // Largest window the chain can hold, as a window size code.
    localparam size_t K_CAP = (WINDOW_MAX < (1 << CFG_W)) ? CFG_W'(WINDOW_MAX) : '1;

    size_t     k_reg;
    size_t     fill_reg;
    size_t     fill_next;
    size_t     eff_fill;
    size_t     k_wr;
    logic      full;
    logic      accept;
    logic      out_adv;
    logic      fire_reg;
    logic      out_valid_reg;
    result_t   median_reg;
    cell_ctl_t ctl;
    sample_t   lo_sel;
    sample_t   hi_sel;

    entry_t    cell_entry [WINDOW_MAX];
    entry_t    cell_shift [WINDOW_MAX];
    logic      cell_gt    [WINDOW_MAX];
    logic      cell_del   [WINDOW_MAX];
    sample_t   cell_lo    [WINDOW_MAX];
    sample_t   cell_hi    [WINDOW_MAX];

    // Output stage moves when it is empty or being drained; the chain may take a
    // sample whenever its pending result can move to the output at the same edge.
    assign out_adv  = !out_valid_reg || out_ready;
    assign in_ready = !fire_reg || out_adv;
    assign accept   = in_valid && in_ready;

    // A restart, or a count left over from a larger window, starts an empty window.
    assign eff_fill  = (restart || (fill_reg > k_reg)) ? '0 : fill_reg;
    assign full      = (eff_fill == k_reg);
    assign fill_next = full ? eff_fill : eff_fill + CFG_W'(1);

    always_comb
    begin
        if (window_size == '0) begin
            k_wr = CFG_W'(1);
        end else if (window_size > K_CAP) begin
            k_wr = K_CAP;
        end else begin
            k_wr = window_size;
        end
    end

    // When full, the oldest entry leaves, so only k-1 survivors stay in the sorted list.
    always_comb
    begin
        ctl.enable = accept;
        ctl.sample = sample;
        ctl.limit  = full ? (k_reg - CFG_W'(1)) : eff_fill;
        ctl.oldest = AGE_W'(k_reg - CFG_W'(1));
        ctl.full   = full;
        ctl.lo_idx = (k_reg - CFG_W'(1)) >> 1;
        ctl.hi_idx = k_reg >> 1;
    end

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        entry_t left_shift;
        logic   left_gt;
        logic   del_in;
        entry_t right_entry;

        if (i == 0) begin : g_first
            assign left_shift = '0;
            assign left_gt    = 1'b0;
            assign del_in     = 1'b0;
        end else begin : g_inner
            assign left_shift = cell_shift[i-1];
            assign left_gt    = cell_gt[i-1];
            assign del_in     = cell_del[i-1];
        end

        if (i == WINDOW_MAX - 1) begin : g_last
            assign right_entry = cell_entry[i];
        end else begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        swm_cell #(
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .left_shift  (left_shift),
            .left_gt     (left_gt),
            .del_in      (del_in),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .shift_entry (cell_shift[i]),
            .gt_out      (cell_gt[i]),
            .del_out     (cell_del[i]),
            .lo_tap      (cell_lo[i]),
            .hi_tap      (cell_hi[i])
        );
    end

    // Exactly one cell answers each middle position, the rest give zero.
    always_comb
    begin
        lo_sel = '0;
        hi_sel = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            lo_sel = lo_sel | cell_lo[i];
            hi_sel = hi_sel | cell_hi[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            k_reg    <= CFG_W'(1);
            fill_reg <= '0;
            fire_reg <= 1'b0;
        end else if (cfg_we) begin
            k_reg    <= k_wr;
            fill_reg <= '0;
            fire_reg <= 1'b0;
        end else if (accept) begin
            fill_reg <= fill_next;
            fire_reg <= (fill_next == k_reg);
        end else if (out_adv) begin
            fire_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= fire_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && fire_reg) begin
            median_reg <= result_t'(lo_sel) + result_t'(hi_sel);
        end
    end

    assign out_valid        = out_valid_reg;
    assign median_times_two = median_reg;

endmodule

### rtl/swm_checker.sv
// Port-level checker for the sliding window median block, bound to its top level.
`include "sliding_window_median_macros.svh"

module swm_checker
    import swm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input result_t median_times_two
);

    // A waiting result keeps its beat and its value until taken.
    `SWM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `SWM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(median_times_two))
    // A result passes from the cell chain, flagged by fire_reg, into the output register, so a
    // rising out_valid goes back to an edge that accepted a sample.
    `SWM_ASSERT_NOW(a_out_cause, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2))
    // With the output register empty the chain always has room for a sample.
    `SWM_ASSERT_NOW(a_ready_empty, clk, rst_n, !out_valid, in_ready)

endmodule

bind sliding_window_median swm_checker u_swm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .median_times_two (median_times_two)
);

### bench/sliding_window_median_checker.sv
// Checker for the sliding window median filter: predicts each median and compares output beats.
module sliding_window_median_checker
    import swm_pkg::*;
#(
    parameter int unsigned WINDOW_MAX = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_we,
    input  size_t   window_size,
    input  logic    in_valid,
    input  logic    in_ready,
    input  sample_t sample,
    input  logic    restart,
    input  logic    out_valid,
    input  logic    out_ready,
    input  result_t median_times_two,
    output int      failures,
    output int      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    sample_t     history [WINDOW_MAX];
    int unsigned span;
    int unsigned held;
    int unsigned oldest;
    int          mismatches;
    result_t     expected_medians [$];

    // Zero counts as one and anything past the window depth saturates.
    function automatic int unsigned clamp_span(size_t raw);
        if (raw == 0)
            return 1;
        if (raw > WINDOW_MAX)
            return WINDOW_MAX;
        return raw;
    endfunction

    // Sorts a copy of the window and adds its two middle elements.
    function automatic result_t window_median();
        sample_t ordered [WINDOW_MAX];
        sample_t pick;
        int      j;
        result_t lower;
        result_t upper;
        for (int i = 0; i < span; i++)
        begin
            pick = history[i];
            j = i;
            while (j > 0 && ordered[j-1] > pick)
            begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = pick;
        end
        lower = ordered[(span - 1) / 2];
        upper = ordered[span / 2];
        return lower + upper;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span       = 1;
            held       = 0;
            oldest     = 0;
            mismatches = 0;
            expected_medians.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                span   = clamp_span(window_size);
                held   = 0;
                oldest = 0;
            end
            if (in_valid && in_ready)
            begin
                if (restart)
                begin
                    held   = 0;
                    oldest = 0;
                end
                if (held < span)
                begin
                    history[held] = sample;
                    held++;
                end
                else
                begin
                    history[oldest] = sample;
                    oldest = (oldest + 1 == span) ? 0 : oldest + 1;
                end
                if (held == span)
                    expected_medians = {expected_medians, window_median()};
            end
            if (out_valid && out_ready)
            begin
                if (expected_medians.size() == 0)
                begin
                    $error("median_times_two: unexpected beat, got %0d", median_times_two);
                    mismatches++;
                end
                else
                begin
                    if (median_times_two !== expected_medians[0])
                    begin
                        $error("median_times_two: expected %0d, got %0d",
                               expected_medians[0], median_times_two);
                        mismatches++;
                    end
                    void'(expected_medians.pop_front());
                end
            end
        end
        failures    <= mismatches;
        outstanding <= expected_medians.size();
    end

endmodule

### bench/sliding_window_median_test.sv
// Top level of the sliding window median testbench: clock, reset, stimulus and verdict.
module sliding_window_median_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swm_pkg::*;

    localparam int unsigned WINDOW_MAX      = 16;
    // Cycles allowed after the last expected median before the block counts as idle.
    localparam int unsigned SETTLE_CYCLES   = 4;
    // Cycles without any beat on either channel before the run is declared hung.
    localparam int unsigned IDLE_LIMIT      = 2000;
    localparam int unsigned ITEMS_PER_PHASE = 135;
    localparam sample_t     SAMPLE_MAX      = sample_t'(32'h7FFF_FFFF);
    localparam sample_t     SAMPLE_MIN      = sample_t'(32'h8000_0000);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    size_t       window_size = size_t'(1);
    logic        in_valid = 1'b0;
    logic        in_ready;
    sample_t     sample = '0;
    logic        restart = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    result_t     median_times_two;
    int          failures;
    int          outstanding;
    int unsigned idle_cycles = 0;
    logic [7:0]  ready_count = '0;

    always #5 clk = ~clk;

    sliding_window_median #(
        .WINDOW_MAX(WINDOW_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .window_size(window_size),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample(sample),
        .restart(restart),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .median_times_two(median_times_two)
    );

    sliding_window_median_checker #(
        .WINDOW_MAX(WINDOW_MAX)
    ) checker_inst (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .window_size(window_size),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample(sample),
        .restart(restart),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .median_times_two(median_times_two),
        .failures(failures),
        .outstanding(outstanding)
    );

    // Gap lengths: mostly none or short, now and then a long pause.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Full-range values most of the time, the two extremes, and a narrow band
    // around zero so that equal samples often share the window.
    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            1, 2, 3: return sample_t'(int'($urandom_range(0, 8)) - 4);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Presents one beat after an optional gap and returns at the edge that
    // accepts it. When the gap is zero, valid stays high across beats and only
    // the payload changes.
    task automatic push_sample(input sample_t value, input logic flag, input int unsigned gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        restart  <= flag;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Writes the window size once the block has gone quiet. The extra edge
    // before polling lets the checker account for a beat accepted on the
    // previous edge, and the settle cycles cover a sample that is still in the
    // cell chain without producing a median.
    task automatic set_window(input size_t value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we      <= 1'b1;
        window_size <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // The receiver alternates between ready bursts and stalls. Some bursts are
    // long so that whole stretches run without back pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            ready_count <= '0;
        end
        else if (ready_count != 0)
        begin
            ready_count <= ready_count - 8'd1;
        end
        else if (out_ready)
        begin
            out_ready   <= 1'b0;
            ready_count <= 8'(pick_gap());
        end
        else
        begin
            out_ready   <= 1'b1;
            ready_count <= ($urandom_range(0, 9) == 0) ? 8'd200 : 8'($urandom_range(0, 24));
        end
    end

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        size_t phase_sizes [$];
        logic  calm;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset window size of one gives a median on every beat, so the
        // extremes show up directly as twice themselves.
        push_sample(SAMPLE_MAX, 1'b0, pick_gap());
        push_sample(SAMPLE_MIN, 1'b0, pick_gap());
        push_sample(sample_t'(0), 1'b1, pick_gap());
        push_sample(sample_t'(-1), 1'b0, pick_gap());

        // Odd window: the middle element counts twice. Three equal maxima give
        // the largest sum, three minima the smallest. A restart mid-stream has
        // to refill the window before the next median appears, and duplicates
        // of the oldest value must leave the result unchanged.
        set_window(size_t'(3));
        push_sample(SAMPLE_MAX, 1'b0, pick_gap());
        push_sample(SAMPLE_MAX, 1'b0, pick_gap());
        push_sample(SAMPLE_MAX, 1'b0, pick_gap());
        push_sample(SAMPLE_MIN, 1'b0, pick_gap());
        push_sample(SAMPLE_MIN, 1'b0, pick_gap());
        push_sample(SAMPLE_MIN, 1'b0, pick_gap());
        push_sample(sample_t'(5), 1'b1, pick_gap());
        push_sample(sample_t'(5), 1'b0, pick_gap());
        push_sample(sample_t'(-7), 1'b0, pick_gap());

        // Even windows: the two middle elements differ, including the pair of
        // opposite extremes whose sum is minus one.
        set_window(size_t'(2));
        push_sample(SAMPLE_MAX, 1'b0, pick_gap());
        push_sample(SAMPLE_MIN, 1'b0, pick_gap());
        push_sample(sample_t'(0), 1'b0, pick_gap());

        set_window(size_t'(4));
        push_sample(sample_t'(10), 1'b0, pick_gap());
        push_sample(sample_t'(-3), 1'b0, pick_gap());
        push_sample(sample_t'(10), 1'b0, pick_gap());
        push_sample(sample_t'(2), 1'b0, pick_gap());
        push_sample(SAMPLE_MIN, 1'b1, pick_gap());

        // Random phases. The list covers the full depth, a size of zero that
        // acts as one, sizes past the depth that saturate, and a couple of
        // random picks. Restarts are rare so most beats land on a full window.
        phase_sizes = '{size_t'(16), size_t'(2), size_t'(0), size_t'(31), size_t'(5),
                        size_t'(17), size_t'(1), size_t'(16), size_t'(8), size_t'(3),
                        size_t'($urandom_range(0, 31)), size_t'($urandom_range(0, 31))};

        foreach (phase_sizes[p])
        begin
            set_window(phase_sizes[p]);
            calm = ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_PHASE)
                push_sample(pick_sample(), $urandom_range(0, 39) == 0,
                            calm ? 0 : pick_gap());
        end

        // Drain: wait for every predicted median, then the settle cycles to catch any
        // stray beat.
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (failures == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
